>>> rtl/echo_ranging_steering_controller_defines.svh
// Assertion macros shared by the echo ranging steering controller RTL.
`ifndef ECHO_RANGING_STEERING_CONTROLLER_DEFINES_SVH
`define ECHO_RANGING_STEERING_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define ERC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("erc assertion failed");
`define ERC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("erc assertion failed");
`else
`define ERC_ASSERT_SAME(name, ante, cons)
`define ERC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> rtl/erc_pkg.sv
// Types and constants of the echo ranging steering controller.
package erc_pkg;

    localparam int THRESH_W   = 9;
    localparam int TICK_W     = 20;
    localparam int MOTOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int NUM_LANES  = 3;

    localparam int LANE_LEFT  = 0;
    localparam int LANE_FRONT = 1;
    localparam int LANE_RIGHT = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_TICKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_TICKS     = 3'd4;

    localparam logic [THRESH_W-1:0] RST_RANGE_THRESHOLD = 9'd153;
    localparam logic [TICK_W-1:0]   RST_TRIGGER_TICKS   = 20'd2;
    localparam logic [TICK_W-1:0]   RST_SETTLE_TICKS    = 20'd3571;
    localparam logic [TICK_W-1:0]   RST_TURN_TICKS      = 20'd85714;
    localparam logic [TICK_W-1:0]   RST_START_TICKS     = 20'd28571;

    localparam logic [MOTOR_W-1:0] CODE_NONE    = 8'h00;
    localparam logic [MOTOR_W-1:0] CODE_FORWARD = 8'hAA;
    localparam logic [MOTOR_W-1:0] CODE_LEFT    = 8'h66;
    localparam logic [MOTOR_W-1:0] CODE_RIGHT   = 8'h99;

    typedef enum logic [2:0] {
        PH_START,
        PH_TRIGGER,
        PH_WAIT,
        PH_MEASURE,
        PH_SETTLE,
        PH_TURN
    } phase_t;

    typedef struct packed {
        logic clear;
        logic count_en;
    } lane_ctl_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] code;
        logic               turn;
        logic               lamp_set;
    } steer_t;

endpackage

>>> rtl/erc_ifs.sv
// Handshake channel interfaces: echo samples in, motor results out, register writes.
interface erc_echo_if;
    logic valid;
    logic ready;
    logic echo_left;
    logic echo_front;
    logic echo_right;

    modport source (output valid, output echo_left, output echo_front, output echo_right,
                    input ready);
    modport sink (input valid, input echo_left, input echo_front, input echo_right,
                  output ready);
endinterface

interface erc_motor_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger_out;
    logic [erc_pkg::MOTOR_W-1:0] motor_code;
    logic                        motor_write;
    logic                        obstacle_lamp;

    modport source (output valid, output trigger_out, output motor_code,
                    output motor_write, output obstacle_lamp, input ready);
    modport sink (input valid, input trigger_out, input motor_code,
                  input motor_write, input obstacle_lamp, output ready);
endinterface

interface erc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [erc_pkg::CFG_IDX_W-1:0]  index;
    logic [erc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/erc_lane.sv
// One echo channel lane: a saturating tick counter for the time its echo is high.
module erc_lane #(
    parameter int COUNT_CAP = 256,
    localparam int CntW = $clog2(COUNT_CAP + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  erc_pkg::lane_ctl_t ctl,
    input  logic               echo,
    output logic [CntW-1:0]    count,
    output logic               active
);

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign active = echo && (count_reg < CntW'(COUNT_CAP));

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.count_en && active)
        begin
            count_next = count_reg + CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

>>> rtl/erc_steer.sv
// Merging stage: compares the three lane counts with the threshold and picks a motor code.
module erc_steer #(
    parameter int COUNT_CAP = 256,
    localparam int CntW = $clog2(COUNT_CAP + 1),
    localparam int CmpW = (CntW > erc_pkg::THRESH_W) ? CntW : erc_pkg::THRESH_W
) (
    input  logic [CntW-1:0]              left_count,
    input  logic [CntW-1:0]              front_count,
    input  logic [CntW-1:0]              right_count,
    input  logic [erc_pkg::THRESH_W-1:0] threshold,
    output erc_pkg::steer_t              steer
);

    logic [CmpW-1:0] thr_ext;
    logic [CmpW-1:0] left_ext;
    logic [CmpW-1:0] front_ext;
    logic [CmpW-1:0] right_ext;

    assign thr_ext   = CmpW'(threshold);
    assign left_ext  = CmpW'(left_count);
    assign front_ext = CmpW'(front_count);
    assign right_ext = CmpW'(right_count);

    // Priority: right blocked (lamp only, straight on), then front blocked, then left far, else straight on.
    always_comb
    begin
        steer.code     = erc_pkg::CODE_FORWARD;
        steer.turn     = 1'b0;
        steer.lamp_set = 1'b0;
        if (right_ext < thr_ext)
        begin
            steer.lamp_set = 1'b1;
        end
        else if (front_ext < thr_ext)
        begin
            steer.code = erc_pkg::CODE_LEFT;
            steer.turn = 1'b1;
        end
        else if (left_ext > thr_ext)
        begin
            steer.code = erc_pkg::CODE_RIGHT;
            steer.turn = 1'b1;
        end
    end

endmodule

>>> rtl/echo_ranging_steering_controller.sv
// Top level: phase sequencer, delay timer, three echo lanes, steering merge, output register.
//
//  channel | role   | payload                                            | handshake
//  echo    | sink   | echo_left, echo_front, echo_right                  | valid/ready
//  motor   | source | trigger_out, motor_code, motor_write, obstacle_lamp | valid/ready
//  cfg     | sink   | index (3 bits), data (20 bits)                     | valid/ready
//
// Each echo transaction is one tick and yields one motor transaction from the output register in the next cycle.
// A new tick is taken every cycle while the output register is empty or being drained,
// so the rate is one tick per cycle, as the phase and lane state update on each taken tick.
// Reset is asynchronous and restores the register defaults and the start-delay phase.
// A stall on the motor side holds the echo side through the output register.
// Register writes are always taken, as cfg.ready is held high.
`include "echo_ranging_steering_controller_defines.svh"

module echo_ranging_steering_controller #(
    parameter int COUNT_CAP = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    erc_echo_if.sink    echo,
    erc_motor_if.source motor,
    erc_cfg_if.sink     cfg
);

    localparam int CntW = $clog2(COUNT_CAP + 1);

    logic [erc_pkg::THRESH_W-1:0] range_threshold_reg;
    logic [erc_pkg::TICK_W-1:0]   trigger_ticks_reg;
    logic [erc_pkg::TICK_W-1:0]   settle_ticks_reg;
    logic [erc_pkg::TICK_W-1:0]   turn_ticks_reg;
    logic [erc_pkg::TICK_W-1:0]   start_ticks_reg;

    erc_pkg::phase_t            phase_reg;
    erc_pkg::phase_t            phase_next;
    logic [erc_pkg::TICK_W-1:0] delay_reg;
    logic [erc_pkg::TICK_W-1:0] delay_next;
    logic [erc_pkg::MOTOR_W-1:0] motor_reg;
    logic [erc_pkg::MOTOR_W-1:0] motor_next;
    logic                        lamp_reg;
    logic                        lamp_next;

    logic                        out_valid_reg;
    logic                        out_trigger_reg;
    logic [erc_pkg::MOTOR_W-1:0] out_code_reg;
    logic                        out_write_reg;
    logic                        out_lamp_reg;

    logic                              accept;
    logic [erc_pkg::NUM_LANES-1:0]     echo_bits;
    logic [erc_pkg::NUM_LANES-1:0]     lane_active;
    logic [CntW-1:0]                   lane_count [erc_pkg::NUM_LANES];
    erc_pkg::lane_ctl_t                lane_ctl;
    erc_pkg::steer_t                   steer;
    logic [erc_pkg::TICK_W-1:0]        limit;
    logic [erc_pkg::TICK_W-1:0]        delay_inc;
    logic                              timer_done;
    logic                              any_echo;
    logic                              any_active;
    logic                              trig_now;
    logic                              write_now;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_threshold_reg <= erc_pkg::RST_RANGE_THRESHOLD;
            trigger_ticks_reg   <= erc_pkg::RST_TRIGGER_TICKS;
            settle_ticks_reg    <= erc_pkg::RST_SETTLE_TICKS;
            turn_ticks_reg      <= erc_pkg::RST_TURN_TICKS;
            start_ticks_reg     <= erc_pkg::RST_START_TICKS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                erc_pkg::REG_RANGE_THRESHOLD:
                    range_threshold_reg <= cfg.data[erc_pkg::THRESH_W-1:0];
                erc_pkg::REG_TRIGGER_TICKS: trigger_ticks_reg <= cfg.data;
                erc_pkg::REG_SETTLE_TICKS:  settle_ticks_reg  <= cfg.data;
                erc_pkg::REG_TURN_TICKS:    turn_ticks_reg    <= cfg.data;
                erc_pkg::REG_START_TICKS:   start_ticks_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    assign echo.ready = !out_valid_reg || motor.ready;
    assign accept     = echo.valid && echo.ready;

    assign echo_bits[erc_pkg::LANE_LEFT]  = echo.echo_left;
    assign echo_bits[erc_pkg::LANE_FRONT] = echo.echo_front;
    assign echo_bits[erc_pkg::LANE_RIGHT] = echo.echo_right;
    assign any_echo   = |echo_bits;
    assign any_active = |lane_active;

    for (genvar g = 0; g < erc_pkg::NUM_LANES; g++)
    begin : g_lane
        erc_lane #(.COUNT_CAP(COUNT_CAP)) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .echo   (echo_bits[g]),
            .count  (lane_count[g]),
            .active (lane_active[g])
        );
    end

    erc_steer #(.COUNT_CAP(COUNT_CAP)) u_steer (
        .left_count  (lane_count[erc_pkg::LANE_LEFT]),
        .front_count (lane_count[erc_pkg::LANE_FRONT]),
        .right_count (lane_count[erc_pkg::LANE_RIGHT]),
        .threshold   (range_threshold_reg),
        .steer       (steer)
    );

    // Timed phases end when the incremented count reaches the limit, so a zero
    // limit still lasts one tick; the wrap to zero also ends the phase.
    always_comb
    begin
        case (phase_reg)
            erc_pkg::PH_TRIGGER: limit = trigger_ticks_reg;
            erc_pkg::PH_SETTLE:  limit = settle_ticks_reg;
            erc_pkg::PH_TURN:    limit = turn_ticks_reg;
            default:             limit = start_ticks_reg;
        endcase
    end

    assign delay_inc  = delay_reg + erc_pkg::TICK_W'(1);
    assign timer_done = (delay_inc >= limit) || (delay_inc == '0);

    always_comb
    begin
        phase_next        = phase_reg;
        delay_next        = delay_reg;
        lane_ctl.clear    = 1'b0;
        lane_ctl.count_en = accept &&
                            ((phase_reg == erc_pkg::PH_WAIT) ||
                             (phase_reg == erc_pkg::PH_MEASURE));
        if (accept)
        begin
            unique case (phase_reg) inside
                erc_pkg::PH_START, erc_pkg::PH_TRIGGER, erc_pkg::PH_TURN:
                begin
                    if (timer_done)
                    begin
                        delay_next = '0;
                        if (phase_reg == erc_pkg::PH_TRIGGER)
                        begin
                            phase_next = erc_pkg::PH_WAIT;
                        end
                        else
                        begin
                            phase_next     = erc_pkg::PH_TRIGGER;
                            lane_ctl.clear = 1'b1;
                        end
                    end
                    else
                    begin
                        delay_next = delay_inc;
                    end
                end
                erc_pkg::PH_WAIT, erc_pkg::PH_MEASURE:
                begin
                    // The tick that first sees an echo already counts.
                    if (phase_reg == erc_pkg::PH_MEASURE || any_echo)
                    begin
                        if (any_active)
                        begin
                            phase_next = erc_pkg::PH_MEASURE;
                        end
                        else
                        begin
                            phase_next = erc_pkg::PH_SETTLE;
                            delay_next = '0;
                        end
                    end
                end
                erc_pkg::PH_SETTLE:
                begin
                    if (timer_done)
                    begin
                        delay_next = '0;
                        if (steer.turn)
                        begin
                            phase_next = erc_pkg::PH_TURN;
                        end
                        else
                        begin
                            phase_next     = erc_pkg::PH_TRIGGER;
                            lane_ctl.clear = 1'b1;
                        end
                    end
                    else
                    begin
                        delay_next = delay_inc;
                    end
                end
                default:
                begin
                    phase_next = erc_pkg::PH_START;
                    delay_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        trig_now   = (phase_reg == erc_pkg::PH_TRIGGER);
        write_now  = (phase_reg == erc_pkg::PH_SETTLE) && timer_done;
        motor_next = motor_reg;
        lamp_next  = lamp_reg;
        if (accept && write_now)
        begin
            motor_next = steer.code;
            lamp_next  = lamp_reg || steer.lamp_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= erc_pkg::PH_START;
            delay_reg     <= '0;
            motor_reg     <= erc_pkg::CODE_NONE;
            lamp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            motor_reg <= motor_next;
            lamp_reg  <= lamp_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (motor.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_trigger_reg <= trig_now;
            out_code_reg    <= motor_next;
            out_write_reg   <= write_now;
            out_lamp_reg    <= lamp_next;
        end
    end

    assign motor.valid         = out_valid_reg;
    assign motor.trigger_out   = out_trigger_reg;
    assign motor.motor_code    = out_code_reg;
    assign motor.motor_write   = out_write_reg;
    assign motor.obstacle_lamp = out_lamp_reg;

    `ERC_ASSERT_SAME(a_write_code_valid, motor.valid && motor.motor_write, motor.motor_code == erc_pkg::CODE_FORWARD || motor.motor_code == erc_pkg::CODE_LEFT || motor.motor_code == erc_pkg::CODE_RIGHT)
    `ERC_ASSERT_NEXT(a_lamp_sticky, lamp_reg, lamp_reg)
    `ERC_ASSERT_SAME(a_turn_has_turn_code, phase_reg == erc_pkg::PH_TURN, motor_reg == erc_pkg::CODE_LEFT || motor_reg == erc_pkg::CODE_RIGHT)
    `ERC_ASSERT_NEXT(a_trigger_clears_lanes, accept && lane_ctl.clear, lane_count[erc_pkg::LANE_LEFT] == '0 && lane_count[erc_pkg::LANE_RIGHT] == '0)

endmodule
